// ----- hdl/hcbd_pkg.sv -----
// hcbd_pkg: shared types, constants and helpers of the chunked body decoder
// used by hcbd_out_if, hcbd_step and http_chunked_body_decoder
package hcbd_pkg;

  localparam int SIZE_BITS = 32;

  typedef logic [SIZE_BITS-1:0] size_t;
  typedef logic [1:0] kind_t;
  typedef logic [2:0] phase_t;

  localparam kind_t KIND_DATA = 2'd0;
  localparam kind_t KIND_END  = 2'd1;
  localparam kind_t KIND_OVF  = 2'd2;

  localparam phase_t PH_SIZE = 3'd0;
  localparam phase_t PH_EXT  = 3'd1;
  localparam phase_t PH_DATA = 3'd2;
  localparam phase_t PH_SKIP = 3'd3;
  localparam phase_t PH_DONE = 3'd4;
  localparam phase_t PH_ERR  = 3'd5;

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    kind_t      kind;
  } result_t;

  function automatic logic hex_ok(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h61) begin
      v = c - 8'h57;
    end else begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

endpackage

// ----- hdl/hcbd_in_if.sv -----
// hcbd_in_if: raw body word channel, valid/ready with byte and first marker
// depends on nothing
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       first;

  modport source (output valid, in_byte, first, input ready);
  modport sink (input valid, in_byte, first, output ready);
endinterface

// ----- hdl/hcbd_out_if.sv -----
// hcbd_out_if: decoded result word channel, valid/ready with byte and kind
// depends on hcbd_pkg
interface hcbd_out_if;
  logic             valid;
  logic             ready;
  logic [7:0]       out_byte;
  hcbd_pkg::kind_t  kind;

  modport source (output valid, out_byte, kind, input ready);
  modport sink (input valid, out_byte, kind, output ready);
endinterface

// ----- hdl/http_chunked_body_decoder.sv -----
// http_chunked_body_decoder: top level of the chunked transfer body decoder
// depends on hcbd_pkg, hcbd_in_if, hcbd_out_if and hcbd_step
//
// usage:
//   in_chan carries one raw body byte per word; first marks the first byte of
//   a new body and restarts the parser before that byte is parsed.
//   out_chan carries at most one result word per input word: a payload byte
//   (kind data), an end of body marker, or a chunk size overflow marker.
//   size lines, chunk extensions, the two bytes after each chunk and any
//   bytes after end of body or overflow give no result word.
// timing:
//   a word accepted into the input register is parsed when it leaves that
//   register, and its result is captured in the result register and shown on out_chan.
//   one word per cycle is taken while out_chan is not stalled; the parse stage sits
//   between an input register and the result register.
// reset and stall:
//   synchronous active-low reset empties both registers and puts the parser
//   at the size digits of a new body with a zero count.
//   while out_chan is stalled with a result held, the input register fills
//   once more and then in_chan.ready drops; nothing is lost or repeated.
module http_chunked_body_decoder (
  input logic       clk,
  input logic       rst_n,
  hcbd_in_if.sink   in_chan,
  hcbd_out_if.source out_chan
);
  import hcbd_pkg::*;

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_first_r;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  kind_t      out_kind_r;

  logic       fire;
  result_t    res;

  assign fire = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || fire;

  hcbd_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .c     (in_byte_r),
    .first (in_first_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_byte_r  <= in_chan.in_byte;
      in_first_r <= in_chan.first;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_chan.ready) begin
      out_valid_r <= fire && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      out_byte_r <= res.data;
      out_kind_r <= res.kind;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_byte = out_byte_r;
  assign out_chan.kind     = out_kind_r;

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && !out_chan.ready |=> in_valid_r)
    else $error("parse stage dropped a word under stall");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_kind_r == KIND_DATA || out_kind_r == KIND_END ||
                    out_kind_r == KIND_OVF)
    else $error("illegal result kind");

  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r != KIND_DATA |-> out_byte_r == 8'd0)
    else $error("marker result with nonzero byte");

endmodule

// ----- hdl/hcbd_step.sv -----
// hcbd_step: parser state and per-byte update of the chunked body decoder
// depends on hcbd_pkg
module hcbd_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        c,
  input  logic              first,
  output hcbd_pkg::result_t res
);
  import hcbd_pkg::*;

  phase_t phase_r, phase_nxt;
  size_t  cnt_r, cnt_nxt;
  logic   cr_r, cr_nxt;
  logic   skip_r, skip_nxt;

  phase_t ph;
  size_t  cnt;
  logic   cr;
  logic   skip;
  size_t  cnt_dec;

  assign ph   = first ? PH_SIZE : phase_r;
  assign cnt  = first ? '0 : cnt_r;
  assign cr   = first ? 1'b0 : cr_r;
  assign skip = first ? 1'b0 : skip_r;
  assign cnt_dec = cnt - size_t'(1);

  always_comb begin
    phase_nxt = ph;
    cnt_nxt   = cnt;
    cr_nxt    = cr;
    skip_nxt  = skip;
    res.valid = 1'b0;
    res.data  = 8'd0;
    res.kind  = KIND_DATA;
    unique case (ph)
      PH_SIZE, PH_EXT: begin
        if (ph == PH_SIZE && hex_ok(c)) begin
          if (cnt[SIZE_BITS-1 -: 4] != 4'd0) begin
            phase_nxt = PH_ERR;
            res.valid = 1'b1;
            res.kind  = KIND_OVF;
          end else begin
            cnt_nxt = {cnt[SIZE_BITS-5:0], hex_val(c)};
          end
        end else begin
          phase_nxt = PH_EXT;
          if (cr && c == CHAR_LF) begin
            cr_nxt = 1'b0;
            if (cnt == '0) begin
              phase_nxt = PH_DONE;
              res.valid = 1'b1;
              res.kind  = KIND_END;
            end else begin
              phase_nxt = PH_DATA;
            end
          end else begin
            cr_nxt = (c == CHAR_CR);
          end
        end
      end
      PH_DATA: begin
        cnt_nxt   = cnt_dec;
        res.valid = 1'b1;
        res.data  = c;
        if (cnt_dec == '0) begin
          phase_nxt = PH_SKIP;
          skip_nxt  = 1'b1;
        end
      end
      PH_SKIP: begin
        if (skip) begin
          skip_nxt = 1'b0;
        end else begin
          phase_nxt = PH_SIZE;
          cnt_nxt   = '0;
          cr_nxt    = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIZE;
      cnt_r   <= '0;
      cr_r    <= 1'b0;
      skip_r  <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      cr_r    <= cr_nxt;
      skip_r  <= skip_nxt;
    end
  end

  a_skip_only_in_skip: assert property (@(posedge clk) disable iff (!rst_n)
    skip_r |-> phase_r == PH_SKIP)
    else $error("skip flag set outside skip phase");

  a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> cnt_r != '0)
    else $error("data phase with zero bytes left");

  a_end_goes_done: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.valid && res.kind == KIND_END |=> phase_r == PH_DONE)
    else $error("end of body did not reach done phase");

endmodule

// ----- test/http_chunked_body_decoder_tb.sv -----
// http_chunked_body_decoder_tb: self-checking bench for the chunked body decoder
// drives raw body words through hcbd_in_if and checks every result word against
// an in-bench parser; depends on hcbd_pkg, hcbd_in_if, hcbd_out_if and the dut
module http_chunked_body_decoder_tb;
  import hcbd_pkg::*;

  typedef struct packed {
    logic       hit;
    logic [7:0] data;
    kind_t      kind;
  } decoded_t;

  typedef struct packed {
    logic [7:0] b;
    logic       f;
    logic       pin;
    logic       has;
    kind_t      k;
    logic [7:0] d;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;

  hcbd_in_if  in_chan();
  hcbd_out_if out_chan();

  http_chunked_body_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // parser state mirrored in the bench
  phase_t walk_phase = PH_SIZE;
  size_t  walk_left  = '0;
  logic   walk_cr    = 1'b0;
  logic   walk_skip  = 1'b0;

  decoded_t   decoded_q[$];
  logic [8:0] body_words[$];
  logic       pending_first = 1'b0;
  int         burst_left = 0;
  int         live_words = 0;
  int         mismatches = 0;

  // pinned rows carry the result that is plain from the bytes
  row_t script [24] = '{
    '{8'h32, 1'b1, 1'b0, 1'b0, KIND_DATA, 8'h00},
    '{8'h3b, 1'b0, 1'b0, 1'b0, KIND_DATA, 8'h00},
    '{CHAR_CR, 1'b0, 1'b1, 1'b0, KIND_DATA, 8'h00},
    '{8'h61, 1'b0, 1'b1, 1'b0, KIND_DATA, 8'h00},
    '{CHAR_CR, 1'b0, 1'b1, 1'b0, KIND_DATA, 8'h00},
    '{CHAR_LF, 1'b0, 1'b1, 1'b0, KIND_DATA, 8'h00},
    '{8'h00, 1'b0, 1'b1, 1'b1, KIND_DATA, 8'h00},
    '{8'hff, 1'b0, 1'b1, 1'b1, KIND_DATA, 8'hff},
    '{8'h78, 1'b0, 1'b1, 1'b0, KIND_DATA, 8'h00},
    '{8'h79, 1'b0, 1'b1, 1'b0, KIND_DATA, 8'h00},
    '{CHAR_LF, 1'b0, 1'b0, 1'b0, KIND_DATA, 8'h00},
    '{CHAR_CR, 1'b0, 1'b0, 1'b0, KIND_DATA, 8'h00},
    '{CHAR_LF, 1'b0, 1'b1, 1'b1, KIND_END, 8'h00},
    '{8'h54, 1'b0, 1'b1, 1'b0, KIND_DATA, 8'h00},
    '{8'h46, 1'b1, 1'b0, 1'b0, KIND_DATA, 8'h00},
    '{8'h46, 1'b0, 1'b0, 1'b0, KIND_DATA, 8'h00},
    '{8'h46, 1'b0, 1'b0, 1'b0, KIND_DATA, 8'h00},
    '{8'h46, 1'b0, 1'b0, 1'b0, KIND_DATA, 8'h00},
    '{8'h46, 1'b0, 1'b0, 1'b0, KIND_DATA, 8'h00},
    '{8'h46, 1'b0, 1'b0, 1'b0, KIND_DATA, 8'h00},
    '{8'h46, 1'b0, 1'b0, 1'b0, KIND_DATA, 8'h00},
    '{8'h46, 1'b0, 1'b0, 1'b0, KIND_DATA, 8'h00},
    '{8'h66, 1'b0, 1'b1, 1'b1, KIND_OVF, 8'h00},
    '{CHAR_CR, 1'b0, 1'b1, 1'b0, KIND_DATA, 8'h00}
  };

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h57);
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h37);
    return -1;
  endfunction

  function automatic decoded_t decode_byte(input logic [7:0] c, input logic mark);
    decoded_t r;
    int dig;
    r = '{1'b0, 8'h00, KIND_DATA};
    if (mark) begin
      walk_phase = PH_SIZE;
      walk_left = '0;
      walk_cr = 1'b0;
      walk_skip = 1'b0;
    end
    dig = hex_digit(c);
    // first non-hex byte ends the number and is parsed as part of the line
    if (walk_phase == PH_SIZE && dig < 0) walk_phase = PH_EXT;
    case (walk_phase)
      PH_SIZE: begin
        if (walk_left[SIZE_BITS-1 -: 4] != 4'd0) begin
          walk_phase = PH_ERR;
          r = '{1'b1, 8'h00, KIND_OVF};
        end else begin
          walk_left = {walk_left[SIZE_BITS-5:0], dig[3:0]};
        end
      end
      PH_EXT: begin
        if (walk_cr && c == CHAR_LF) begin
          walk_cr = 1'b0;
          if (walk_left == '0) begin
            walk_phase = PH_DONE;
            r = '{1'b1, 8'h00, KIND_END};
          end else begin
            walk_phase = PH_DATA;
          end
        end else begin
          walk_cr = (c == CHAR_CR);
        end
      end
      PH_DATA: begin
        walk_left = walk_left - size_t'(1);
        if (walk_left == '0) begin
          walk_phase = PH_SKIP;
          walk_skip = 1'b1;
        end
        r = '{1'b1, c, KIND_DATA};
      end
      PH_SKIP: begin
        if (walk_skip) begin
          walk_skip = 1'b0;
        end else begin
          walk_phase = PH_SIZE;
          walk_left = '0;
          walk_cr = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void add_word(input logic [7:0] b);
    body_words.push_back({pending_first, b});
    pending_first = 1'b0;
  endfunction

  function automatic void add_size(input logic [31:0] n);
    int digits;
    logic [3:0] nib;
    digits = 1;
    while (digits < 8 && (n >> (4 * digits)) != 0) digits++;
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 2)) add_word(8'h30);
    for (int i = digits - 1; i >= 0; i--) begin
      nib = n[4*i +: 4];
      if (nib < 4'd10) add_word(8'h30 + {4'h0, nib});
      else if ($urandom_range(0, 1) == 1) add_word(8'h37 + {4'h0, nib});
      else add_word(8'h57 + {4'h0, nib});
    end
  endfunction

  // optional extension, optional lone cr, then cr lf
  function automatic void add_line_tail();
    logic [7:0] b;
    if ($urandom_range(0, 2) == 0) begin
      add_word(8'h3b);
      repeat ($urandom_range(0, 5)) begin
        b = 8'($urandom_range(0, 255));
        if (b == CHAR_CR) b = 8'h20;
        add_word(b);
      end
    end
    if ($urandom_range(0, 4) == 0) begin
      b = 8'($urandom_range(0, 255));
      if (b == CHAR_LF) b = 8'h41;
      add_word(CHAR_CR);
      add_word(b);
    end
    add_word(CHAR_CR);
    add_word(CHAR_LF);
  endfunction

  function automatic void add_body(input logic cut);
    logic [31:0] n;
    int target;
    pending_first = 1'b1;
    repeat ($urandom_range(1, 4)) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 200) : $urandom_range(1, 16);
      if (cut && $urandom_range(0, 3) == 0) n = $urandom();
      if (n == 0) n = 1;
      add_size(n);
      add_line_tail();
      for (int i = 0; i < n && i < 400; i++) add_word(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) != 0) begin
        add_word(CHAR_CR);
        add_word(CHAR_LF);
      end else begin
        add_word(8'($urandom_range(0, 255)));
        add_word(8'($urandom_range(0, 255)));
      end
    end
    // last chunk: plain zero, padded zeros or no digits at all
    case ($urandom_range(0, 3))
      0: add_word(8'h30);
      1: repeat ($urandom_range(2, 4)) add_word(8'h30);
      2: ;
      default: add_size(0);
    endcase
    add_line_tail();
    repeat ($urandom_range(0, 5)) add_word(8'($urandom_range(0, 255)));
    if (cut) begin
      target = $urandom_range(1, body_words.size());
      while (body_words.size() > target) void'(body_words.pop_back());
    end
  endfunction

  task automatic push_word(input logic [7:0] b, input logic mark, input logic pin,
                           input decoded_t pinned);
    decoded_t res;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 30);
    end
    burst_left--;
    in_chan.valid   <= 1'b1;
    in_chan.in_byte <= b;
    in_chan.first   <= mark;
    do @(posedge clk); while (!in_chan.ready);
    // bytes dropped after end of body or overflow do not count
    if (mark || (walk_phase != PH_DONE && walk_phase != PH_ERR)) live_words++;
    res = decode_byte(b, mark);
    if (pin) res = pinned;
    if (res.hit) decoded_q.push_back(res);
  endtask

  // receiver stall pattern, picked anew each time the tick counter wraps
  logic [7:0] rcv_tick = '0;
  int rcv_mode = 0;
  always @(posedge clk) begin
    rcv_tick <= rcv_tick + 1'b1;
    if (rcv_tick == 8'd0) rcv_mode <= $urandom_range(0, 3);
    case (rcv_mode)
      0: out_chan.ready <= 1'b1;
      1: out_chan.ready <= (rcv_tick[1:0] != 2'd3);
      2: out_chan.ready <= ($urandom_range(0, 1) == 1);
      default: out_chan.ready <= (rcv_tick[4:0] < 5'd6);
    endcase
  end

  always @(posedge clk) begin
    decoded_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: result with none expected, got kind %0d byte %02h",
                 $time, out_chan.kind, out_chan.out_byte);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        if (out_chan.kind !== want.kind) begin
          $display("%0t: kind expected %0d got %0d", $time, want.kind, out_chan.kind);
          mismatches++;
        end
        if (out_chan.out_byte !== want.data) begin
          $display("%0t: byte expected %02h got %02h", $time, want.data,
                   out_chan.out_byte);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("http_chunked_body_decoder_tb: errors");
    $finish;
  end

  initial begin
    int round;
    int pick;
    logic [8:0] w;
    logic [7:0] b;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.in_byte = 8'h00;
    in_chan.first = 1'b0;
    out_chan.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      push_word(script[i].b, script[i].f, script[i].pin,
                '{script[i].has, script[i].d, script[i].k});
    end

    round = 0;
    while (live_words < 1700) begin
      if (round == 3 || $urandom_range(0, 24) == 0) begin
        in_chan.valid <= 1'b0;
        do @(posedge clk); while (decoded_q.size() != 0);
      end
      body_words.delete();
      pick = $urandom_range(0, 9);
      case (pick)
        6: add_body(1'b1);
        7: begin
          // nine or more digits with a nonzero lead overflow the counter
          pending_first = 1'b1;
          add_word(8'h30 + 8'($urandom_range(1, 9)));
          repeat ($urandom_range(8, 9)) add_word(8'h30 + 8'($urandom_range(0, 9)));
          repeat ($urandom_range(0, 4)) add_word(8'($urandom_range(0, 255)));
        end
        8: begin
          repeat ($urandom_range(1, 20)) begin
            case ($urandom_range(0, 3))
              0: b = 8'($urandom_range(0, 255));
              1: b = 8'h30 + 8'($urandom_range(0, 9));
              2: b = CHAR_CR;
              default: b = CHAR_LF;
            endcase
            body_words.push_back({($urandom_range(0, 15) == 0), b});
          end
        end
        default: add_body(1'b0);
      endcase
      while (body_words.size() != 0) begin
        w = body_words.pop_front();
        push_word(w[7:0], w[8], 1'b0, '0);
      end
      round++;
    end

    in_chan.valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("http_chunked_body_decoder_tb: clean");
    end else begin
      $display("http_chunked_body_decoder_tb: errors");
    end
    $finish;
  end

endmodule

// ----- http_chunked_body_decoder.f -----
hdl/hcbd_pkg.sv
hdl/hcbd_in_if.sv
hdl/hcbd_out_if.sv
hdl/hcbd_step.sv
hdl/http_chunked_body_decoder.sv
test/http_chunked_body_decoder_tb.sv
